// ===== src/load_average_tracker_assert.svh =====
// assertion macros for the load average tracker
`ifndef LOAD_AVERAGE_TRACKER_ASSERT_SVH
`define LOAD_AVERAGE_TRACKER_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define LAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lat assertion failed");

// next-cycle implication
`define LAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lat assertion failed");

`else

`define LAT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/lat_pkg.sv =====
// shared types and constants of the load average tracker
`timescale 1ns / 1ps

package lat_pkg;

	localparam int TIME_W      = 64;
	localparam int GAP_W       = 16;
	localparam int PERIOD_W    = 24;
	localparam int TASKS_W     = 7;
	localparam int TASK_CMP_W  = 11;
	localparam int SUM_W       = 40;
	localparam int COUNT_W     = 32;
	localparam int LOAD_W      = 17;
	localparam int OUT_W       = 16;
	localparam int DIVIDEND_W  = 50;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 24;

	localparam int MAX_TASKS_DEFAULT = 64;

	localparam logic [GAP_W-1:0]    GAP_RESET    = GAP_W'(1000);
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(500000);

	localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_GAP  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_ACCT_PERIOD = CFG_INDEX_W'(1);

	localparam logic OP_SAMPLE     = 1'b0;
	localparam logic OP_ACCOUNTING = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_SCALE,
		ST_DIVIDE,
		ST_SMOOTH_SHORT,
		ST_SMOOTH_LONG,
		ST_OUTPUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic take_sample;
		logic advance;
		logic scale;
		logic load_instant;
		logic smooth_short;
		logic smooth_long;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic op;
		logic gap_ok;
		logic acct_due;
		logic count_nz;
		logic div_done;
	} dp_status_t;

endpackage

// ===== src/load_average_tracker.sv =====
// top level of the load average tracker
`timescale 1ns / 1ps

// load average tracker: every transfer on the input channel yields exactly one
// transfer on the output channel carrying the instant, short and long loads
// (times 1000, clipped to 16 bits) after that item, plus flags that tell
// whether a sample item was counted or an accounting item recomputed the
// averages. a sample item or an accounting item that is not yet due goes
// straight to the output; a due accounting item smooths the short and long
// averages first and, if it has samples, before that forms sum * 1000 /
// count in the bit-serial divider, one quotient bit per cycle over 50 bits.
// the input is taken again as soon as the sequencer is back in idle, even
// while the previous result still sits in the output register. the two
// configuration registers (index 0 sample gap, index 1 accounting period)
// are written through cfg_write/cfg_index/cfg_data and must only change
// while no item is in flight; writes to other indexes are dropped.
module load_average_tracker #(
	parameter int MAX_TASKS = lat_pkg::MAX_TASKS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_write,
	input  logic [lat_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lat_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            operation,
	input  logic [lat_pkg::TIME_W-1:0]      time_us,
	input  logic [lat_pkg::TASKS_W-1:0]     runnable_tasks,
	// output channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [lat_pkg::OUT_W-1:0]       load_instant,
	output logic [lat_pkg::OUT_W-1:0]       load_short,
	output logic [lat_pkg::OUT_W-1:0]       load_long,
	output logic                            sample_taken,
	output logic                            averages_updated
);
	import lat_pkg::*;

	// commands from the sequencer, status back from the datapath
	ctrl_cmd_t  cmd;
	dp_status_t status;

	lat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath holds config, tracker state, the divider and the output register
	lat_datapath #(
		.MAX_TASKS (MAX_TASKS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.operation        (operation),
		.time_us          (time_us),
		.runnable_tasks   (runnable_tasks),
		.cmd              (cmd),
		.status           (status),
		.load_instant     (load_instant),
		.load_short       (load_short),
		.load_long        (load_long),
		.sample_taken     (sample_taken),
		.averages_updated (averages_updated)
	);

endmodule

// ===== src/lat_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module lat_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [lat_pkg::DIVIDEND_W-1:0]  dividend,
	input  logic [lat_pkg::COUNT_W-1:0]     divisor,
	output logic [lat_pkg::DIVIDEND_W-1:0]  quotient,
	output logic                            done
);
	import lat_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

	logic [COUNT_W-1:0]    divisor_q;
	logic [COUNT_W-1:0]    rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [COUNT_W:0]   shifted;
	logic [COUNT_W+1:0] diff;

	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff    = {1'b0, shifted} - {2'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			quo_q     <= dividend;
		end else if (busy_q) begin
			if (!diff[COUNT_W+1]) begin
				rem_q <= diff[COUNT_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[COUNT_W-1:0];
				quo_q <= {quo_q[DIVIDEND_W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== src/lat_datapath.sv =====
// state, arithmetic and output register of the load average tracker
`timescale 1ns / 1ps

module lat_datapath #(
	parameter int MAX_TASKS = lat_pkg::MAX_TASKS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [lat_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [lat_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            operation,
	input  logic [lat_pkg::TIME_W-1:0]      time_us,
	input  logic [lat_pkg::TASKS_W-1:0]     runnable_tasks,
	input  lat_pkg::ctrl_cmd_t              cmd,
	output lat_pkg::dp_status_t             status,
	output logic [lat_pkg::OUT_W-1:0]       load_instant,
	output logic [lat_pkg::OUT_W-1:0]       load_short,
	output logic [lat_pkg::OUT_W-1:0]       load_long,
	output logic                            sample_taken,
	output logic                            averages_updated
);
	import lat_pkg::*;

	localparam logic [TASK_CMP_W-1:0] MAX_T = TASK_CMP_W'(MAX_TASKS);
	localparam logic [LOAD_W-1:0]     LOAD_MAX = '1;

	function automatic logic [LOAD_W-1:0] low_pass(input logic [LOAD_W-1:0] prev,
			input logic [LOAD_W-1:0] in_load);
		logic [LOAD_W+4:0] acc;
		acc = {1'b0, prev, 4'b0} - {5'b0, prev} + {5'b0, in_load} + (LOAD_W+5)'(8);
		return acc[LOAD_W+4] ? LOAD_MAX : acc[LOAD_W+3:4];
	endfunction

	function automatic logic [OUT_W-1:0] sat_out(input logic [LOAD_W-1:0] v);
		return v[LOAD_W-1] ? '1 : v[OUT_W-1:0];
	endfunction

	// configuration
	logic [GAP_W-1:0]    gap_q;
	logic [PERIOD_W-1:0] period_q;

	// tracker state
	logic [TIME_W-1:0]  last_q;
	logic [TIME_W-1:0]  next_q;
	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] count_q;
	logic [LOAD_W-1:0]  inst_q;
	logic [LOAD_W-1:0]  short_q;
	logic [LOAD_W-1:0]  long_q;

	// captured item
	logic               op_q;
	logic [TIME_W-1:0]  time_q;
	logic [TASKS_W-1:0] tasks_q;
	logic               taken_q;
	logic               updated_q;

	// output register
	logic [OUT_W-1:0] out_inst_q;
	logic [OUT_W-1:0] out_short_q;
	logic [OUT_W-1:0] out_long_q;
	logic             out_taken_q;
	logic             out_updated_q;

	logic [TIME_W-1:0]     elapsed;
	logic [TIME_W:0]       next_sum;
	logic [TIME_W-1:0]     next_val;
	logic [TASKS_W-1:0]    tasks_clamped;
	logic [TASKS_W-1:0]    tasks_add;
	logic [SUM_W:0]        sum_next;
	logic [DIVIDEND_W-1:0] sum_ext;
	logic [DIVIDEND_W-1:0] scaled;
	logic [DIVIDEND_W-1:0] quotient;
	logic                  div_done;
	logic [LOAD_W-1:0]     inst_next;

	assign elapsed  = time_q - last_q;
	assign next_sum = {1'b0, time_q} + {{(TIME_W-PERIOD_W+1){1'b0}}, period_q};
	assign next_val = next_sum[TIME_W] ? '1 : next_sum[TIME_W-1:0];

	assign tasks_clamped = ({{(TASK_CMP_W-TASKS_W){1'b0}}, tasks_q} > MAX_T) ?
		MAX_T[TASKS_W-1:0] : tasks_q;
	assign tasks_add = (tasks_clamped == '0) ? '0 : tasks_clamped - TASKS_W'(1);
	assign sum_next  = {1'b0, sum_q} + {{(SUM_W-TASKS_W+1){1'b0}}, tasks_add};

	// times 1000 as 1024 - 16 - 8
	assign sum_ext = {{(DIVIDEND_W-SUM_W){1'b0}}, sum_q};
	assign scaled  = (sum_ext << 10) - (sum_ext << 4) - (sum_ext << 3);

	assign inst_next = (|quotient[DIVIDEND_W-1:LOAD_W]) ? LOAD_MAX : quotient[LOAD_W-1:0];

	lat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.scale),
		.dividend (scaled),
		.divisor  (count_q),
		.quotient (quotient),
		.done     (div_done)
	);

	assign status.op       = op_q;
	assign status.gap_ok   = elapsed > {{(TIME_W-GAP_W){1'b0}}, gap_q};
	assign status.acct_due = time_q >= next_q;
	assign status.count_nz = count_q != '0;
	assign status.div_done = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q    <= GAP_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_write) begin
			if (cfg_index == CFG_SAMPLE_GAP) begin
				gap_q <= cfg_data[GAP_W-1:0];
			end else if (cfg_index == CFG_ACCT_PERIOD) begin
				period_q <= cfg_data[PERIOD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			next_q  <= '0;
			sum_q   <= '0;
			count_q <= '0;
			inst_q  <= '0;
			short_q <= '0;
			long_q  <= '0;
		end else begin
			if (cmd.take_sample) begin
				sum_q   <= sum_next[SUM_W] ? '1 : sum_next[SUM_W-1:0];
				count_q <= (&count_q) ? count_q : count_q + COUNT_W'(1);
				last_q  <= time_q;
			end
			if (cmd.advance) begin
				next_q <= next_val;
			end
			if (cmd.scale) begin
				sum_q   <= '0;
				count_q <= '0;
			end
			if (cmd.load_instant) begin
				inst_q <= inst_next;
			end
			if (cmd.smooth_short) begin
				short_q <= low_pass(short_q, inst_q);
			end
			if (cmd.smooth_long) begin
				long_q <= low_pass(long_q, short_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= operation;
			time_q    <= time_us;
			tasks_q   <= runnable_tasks;
			taken_q   <= 1'b0;
			updated_q <= 1'b0;
		end else begin
			if (cmd.take_sample) begin
				taken_q <= 1'b1;
			end
			if (cmd.advance) begin
				updated_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			out_inst_q    <= sat_out(inst_q);
			out_short_q   <= sat_out(short_q);
			out_long_q    <= sat_out(long_q);
			out_taken_q   <= taken_q;
			out_updated_q <= updated_q;
		end
	end

	assign load_instant     = out_inst_q;
	assign load_short       = out_short_q;
	assign load_long        = out_long_q;
	assign sample_taken     = out_taken_q;
	assign averages_updated = out_updated_q;

endmodule

// ===== src/lat_ctrl.sv =====
// sequencing state machine of the load average tracker
`timescale 1ns / 1ps

`include "load_average_tracker_assert.svh"

module lat_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  lat_pkg::dp_status_t status,
	output lat_pkg::ctrl_cmd_t  cmd
);
	import lat_pkg::*;

	state_t state_q;
	state_t state_next;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_next = ST_EVAL;
				end
			end
			ST_EVAL: begin
				if (status.op == OP_ACCOUNTING && status.acct_due) begin
					state_next = status.count_nz ? ST_SCALE : ST_SMOOTH_SHORT;
				end else begin
					state_next = ST_OUTPUT;
				end
			end
			ST_SCALE: state_next = ST_DIVIDE;
			ST_DIVIDE: begin
				if (status.div_done) begin
					state_next = ST_SMOOTH_SHORT;
				end
			end
			ST_SMOOTH_SHORT: state_next = ST_SMOOTH_LONG;
			ST_SMOOTH_LONG: state_next = ST_OUTPUT;
			ST_OUTPUT: begin
				if (out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: cmd.capture = in_valid;
			ST_EVAL: begin
				cmd.take_sample = (status.op == OP_SAMPLE) && status.gap_ok;
				cmd.advance     = (status.op == OP_ACCOUNTING) && status.acct_due;
			end
			ST_SCALE: cmd.scale = 1'b1;
			ST_DIVIDE: cmd.load_instant = status.div_done;
			ST_SMOOTH_SHORT: cmd.smooth_short = 1'b1;
			ST_SMOOTH_LONG: cmd.smooth_long = 1'b1;
			ST_OUTPUT: cmd.load_out = out_free;
			default: cmd = '0;
		endcase
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	`LAT_ASSERT_IMP(a_load_out_free, clk, arst_n, cmd.load_out, out_free)
	`LAT_ASSERT_NEXT(a_capture_eval, clk, arst_n, cmd.capture, state_q == ST_EVAL)
	`LAT_ASSERT_IMP(a_div_done_divide, clk, arst_n, status.div_done, state_q == ST_DIVIDE)
	`LAT_ASSERT_NEXT(a_scale_clears, clk, arst_n, cmd.scale, !status.count_nz)

endmodule
